>>> sv/nds_pkg.sv
// Shared types, constants and digit helpers for the nixie digit scroll sequencer.
package nds_pkg;

  localparam int DigitCountDefault = 6;
  localparam int DigitMaxCount     = 8;

  typedef logic [6:0] time_val_t;
  typedef logic [7:0] byte_t;
  typedef logic [3:0] digit_t;

  localparam digit_t DigitNine = 4'd9;
  localparam digit_t DigitZero = 4'd0;

  // Chain signals handed from one digit cell to the next
  typedef struct packed {
    logic differs;  // some lower digit differs from its request
    logic free;     // no lower digit is still pending
    logic busy;     // some lower digit is pending after this tick
  } chain_t;

  // Per-tick control broadcast to every cell
  typedef struct packed {
    logic latch;    // load targets on this accepted request
    logic run;      // scroll step allowed on this accepted request
  } cell_ctl_t;

  // Tens of a 7-bit value: (v * 205) >> 11 is exact below 1029
  function automatic logic [3:0] tens_of(input time_val_t v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

  // Ones digit: v - 10 * tens
  function automatic digit_t ones_of(input time_val_t v);
    logic [3:0] t;
    logic [6:0] rem;
    t   = tens_of(v);
    rem = v - (7'(t) * 7'd10);
    return rem[3:0];
  endfunction

  // Tens digit taken mod 10 (tens of a 7-bit value stays below 13)
  function automatic digit_t tens_digit_of(input time_val_t v);
    logic [3:0] t;
    t = tens_of(v);
    return (t > DigitNine) ? (t - 4'd10) : t;
  endfunction

endpackage

>>> sv/nds_if.sv
// Request and frame channel interfaces for the nixie digit scroll sequencer.
interface nds_in_if;
  import nds_pkg::*;

  logic      valid;
  logic      ready;
  time_val_t req_hours;
  time_val_t req_minutes;
  time_val_t req_seconds;
  byte_t     divider_in;

  modport source (output valid, output req_hours, output req_minutes,
                  output req_seconds, output divider_in, input ready);
  modport sink   (input valid, input req_hours, input req_minutes,
                  input req_seconds, input divider_in, output ready);
endinterface

interface nds_out_if;
  import nds_pkg::*;

  logic  valid;
  logic  ready;
  byte_t hours_byte;
  byte_t minutes_byte;
  byte_t seconds_byte;
  byte_t divider_byte;
  logic  new_frame;
  logic  busy_res;

  modport source (output valid, output hours_byte, output minutes_byte,
                  output seconds_byte, output divider_byte, output new_frame,
                  output busy_res, input ready);
  modport sink   (input valid, input hours_byte, input minutes_byte,
                  input seconds_byte, input divider_byte, input new_frame,
                  input busy_res, output ready);
endinterface

>>> sv/nixie_digit_scroll_sequencer_core.sv
// Top level of the nixie digit scroll sequencer: digit cell row and frame register.
//
// in_chan carries one frame tick per request: requested hours, minutes and
// seconds plus a divider lamp byte. out_chan returns exactly one frame per
// request: packed digits (tens in the low nibble, ones in the high nibble),
// the held divider, new_frame when a digit stepped and busy_res while the
// scroll goes on. When idle and any requested digit differs from the shown
// one, targets and divider are loaded and the first step is taken on the
// same tick; requests that arrive while scrolling only advance the scroll.
// Each tick moves the lowest pending digit by one, counting up through 9.
// Frames are registered, valid in the cycle after accept; one request is taken
// every cycle while out_chan is ready, set by the single pass through the cells.
// The frame register frees in_chan.ready whenever it is empty or being
// taken, so a stalled receiver holds the frame and back-pressures requests.
// Reset clears all digits, targets, the divider and the scrolling flag.
module nixie_digit_scroll_sequencer_core #(
  parameter int DIGIT_COUNT = nds_pkg::DigitCountDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  nds_in_if.sink    in_chan,
  nds_out_if.source out_chan
);
  import nds_pkg::*;

  logic      scrolling_r, scrolling_nxt;
  byte_t     divider_r, divider_nxt;
  logic      out_valid_r, out_valid_nxt;
  byte_t     hours_r, minutes_r, seconds_r, div_out_r;
  logic      frame_r, busy_r;

  logic      accept;
  logic      latch;
  logic      scroll_eff;
  logic      stepped;
  cell_ctl_t ctl;
  digit_t    req_d   [DigitMaxCount];
  digit_t    shown_d [DigitMaxCount];
  chain_t    chain   [DIGIT_COUNT+1];

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Split requests into decimal digits, lowest first
  always_comb begin
    for (int i = 0; i < DigitMaxCount; i++) begin
      req_d[i] = DigitZero;
    end
    req_d[0] = ones_of(in_chan.req_seconds);
    req_d[1] = tens_digit_of(in_chan.req_seconds);
    req_d[2] = ones_of(in_chan.req_minutes);
    req_d[3] = tens_digit_of(in_chan.req_minutes);
    req_d[4] = ones_of(in_chan.req_hours);
    req_d[5] = tens_digit_of(in_chan.req_hours);
  end

  assign chain[0] = '{differs: 1'b0, free: 1'b1, busy: 1'b0};

  // Row of digit cells
  for (genvar g = 0; g < DigitMaxCount; g++) begin : g_digit
    if (g < DIGIT_COUNT) begin : g_cell
      nds_digit_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .req_digit  (req_d[g]),
        .chain_in   (chain[g]),
        .chain_out  (chain[g+1]),
        .shown_next (shown_d[g])
      );
    end else begin : g_pad
      assign shown_d[g] = DigitZero;
    end
  end

  // Start and step control
  always_comb begin
    latch         = !scrolling_r && chain[DIGIT_COUNT].differs;
    scroll_eff    = scrolling_r || latch;
    ctl.latch     = accept && latch;
    ctl.run       = accept && scroll_eff;
    stepped       = scroll_eff && !chain[DIGIT_COUNT].free;
    scrolling_nxt = scrolling_r;
    divider_nxt   = divider_r;
    if (accept) begin
      scrolling_nxt = scroll_eff && chain[DIGIT_COUNT].busy;
      if (latch) begin
        divider_nxt = in_chan.divider_in;
      end
    end
  end

  // Hold the frame until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scrolling_r <= 1'b0;
      divider_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scrolling_r <= scrolling_nxt;
      divider_r   <= divider_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load frame payload on each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      hours_r   <= {shown_d[4], shown_d[5]};
      minutes_r <= {shown_d[2], shown_d[3]};
      seconds_r <= {shown_d[0], shown_d[1]};
      div_out_r <= divider_nxt;
      frame_r   <= stepped;
      busy_r    <= scrolling_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.hours_byte   = hours_r;
  assign out_chan.minutes_byte = minutes_r;
  assign out_chan.seconds_byte = seconds_r;
  assign out_chan.divider_byte = div_out_r;
  assign out_chan.new_frame    = frame_r;
  assign out_chan.busy_res     = busy_r;

endmodule

>>> sv/nds_digit_cell.sv
// One digit cell: shown digit, target digit and wrap flag, with chain links.
module nds_digit_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  nds_pkg::cell_ctl_t ctl,
  input  nds_pkg::digit_t    req_digit,
  input  nds_pkg::chain_t    chain_in,
  output nds_pkg::chain_t    chain_out,
  output nds_pkg::digit_t    shown_next
);
  import nds_pkg::*;

  digit_t shown_r, shown_nxt;
  digit_t target_r, target_nxt;
  logic   passed_r, passed_nxt;

  logic   passed_v;
  logic   pending;
  logic   step;
  logic   wrap;

  // Latch target, pick the step, advance the digit
  always_comb begin
    target_nxt = ctl.latch ? req_digit : target_r;
    passed_v   = ctl.latch ? (req_digit == shown_r) : passed_r;
    pending    = !(passed_v && (shown_r == target_nxt));
    step       = ctl.run && pending && chain_in.free;
    wrap       = (shown_r >= DigitNine);
    shown_nxt  = shown_r;
    passed_nxt = passed_v;
    if (step) begin
      if (wrap) begin
        shown_nxt  = DigitZero;
        passed_nxt = 1'b1;
      end else begin
        shown_nxt  = shown_r + 4'd1;
      end
    end
  end

  // Hand chain state to the next digit up
  always_comb begin
    chain_out.differs = chain_in.differs || (req_digit != shown_r);
    chain_out.free    = chain_in.free && !pending;
    chain_out.busy    = chain_in.busy || !(passed_nxt && (shown_nxt == target_nxt));
  end

  assign shown_next = shown_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r  <= DigitZero;
      target_r <= DigitZero;
      passed_r <= 1'b0;
    end else begin
      shown_r  <= shown_nxt;
      target_r <= target_nxt;
      passed_r <= passed_nxt;
    end
  end

endmodule
